FILE: design/mmf_pkg.sv
// Shared types, codes and defaults for the message mailbox FIFO.
`default_nettype none

package mmf_pkg;

    // Default geometry of the mailbox.
    localparam int SLOTS_DEF    = 8;
    localparam int MAX_LEN_DEF  = 32;
    localparam int ID_WIDTH_DEF = 8;

    // Fixed widths of the transaction fields.
    localparam int STATUS_W = 3;
    localparam int BYTE_W   = 8;
    localparam int SENDER_W = 8;
    localparam int LENGTH_W = 6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COMMITTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd5;

    // Request type codes.
    localparam logic REQ_SEND = 1'b0;
    localparam logic REQ_RECV = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic send;    // accept one send element
        logic recv;    // accept one receive request
        logic meta;    // metadata of the message being received is ready
        logic stream;  // deliver one stored byte
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;     // no committed message in the ring
        logic zero_len;  // message under receive holds no bytes
        logic rx_last;   // the byte being delivered is the final one
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: design/message_mailbox_fifo_unit.sv
// Top level of the message mailbox FIFO: controller plus datapath.
//
// A send element is taken while busy is low and its single result appears on
// the result ports in the following cycle, so send elements may be given on
// every cycle while busy is low. A receive on an empty ring leaves busy low.
// A receive of a message with stored bytes keeps busy high, first while the
// slot's length and sender are read from their registered store, then while
// the byte memory's read port streams the bytes, one byte per cycle, each
// result registered after its read. A message without bytes holds busy only
// while its length and sender are read. Every result is shown for exactly
// one cycle with o_strobe high and must be taken then; the receiving side
// cannot hold results off.
`default_nettype none

module message_mailbox_fifo_unit #(
    parameter int SLOTS    = mmf_pkg::SLOTS_DEF,
    parameter int MAX_LEN  = mmf_pkg::MAX_LEN_DEF,
    parameter int ID_WIDTH = mmf_pkg::ID_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_req_type,
    input  wire logic [mmf_pkg::SENDER_W-1:0]  i_sender_id,
    input  wire logic [mmf_pkg::BYTE_W-1:0]    i_data_byte,
    input  wire logic                          i_byte_valid,
    input  wire logic                          i_is_last,
    output logic                               o_strobe,
    output logic [mmf_pkg::STATUS_W-1:0]       o_status,
    output logic [mmf_pkg::BYTE_W-1:0]         o_out_byte,
    output logic [mmf_pkg::SENDER_W-1:0]       o_out_sender,
    output logic [mmf_pkg::LENGTH_W-1:0]       o_out_length,
    output logic                               o_out_valid,
    output logic                               o_last
);
    import mmf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Transaction sequencing.
    mmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // Storage and result generation.
    mmf_datapath #(
        .SLOTS    (SLOTS),
        .MAX_LEN  (MAX_LEN),
        .ID_WIDTH (ID_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_sender_id  (i_sender_id),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_is_last    (i_is_last),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_out_byte   (o_out_byte),
        .o_out_sender (o_out_sender),
        .o_out_length (o_out_length),
        .o_out_valid  (o_out_valid),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

FILE: design/mmf_ctrl.sv
// Controller state machine that sequences send and receive transactions.
`default_nettype none

module mmf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic             i_req_type,
    input  wire mmf_pkg::t_dp_sts i_sts,
    output mmf_pkg::t_dp_cmd      o_cmd,
    output logic                  busy
);
    import mmf_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_META   = 2'd1;
    localparam logic [1:0] S_STREAM = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    // A transaction is taken only while idle.
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Commands follow directly from the state and the request.
    assign o_cmd.send   = accept && (i_req_type == REQ_SEND);
    assign o_cmd.recv   = accept && (i_req_type == REQ_RECV);
    assign o_cmd.meta   = (r_state == S_META);
    assign o_cmd.stream = (r_state == S_STREAM);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.recv && !i_sts.empty) n_state = S_META;
            end
            S_META: begin
                n_state = i_sts.zero_len ? S_IDLE : S_STREAM;
            end
            S_STREAM: begin
                if (i_sts.rx_last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: design/mmf_datapath.sv
// Datapath of the mailbox: ring pointers, slot storage and result registers.
`default_nettype none

module mmf_datapath #(
    parameter int SLOTS    = mmf_pkg::SLOTS_DEF,
    parameter int MAX_LEN  = mmf_pkg::MAX_LEN_DEF,
    parameter int ID_WIDTH = mmf_pkg::ID_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mmf_pkg::t_dp_cmd              i_cmd,
    output mmf_pkg::t_dp_sts                   o_sts,
    input  wire logic [mmf_pkg::SENDER_W-1:0]  i_sender_id,
    input  wire logic [mmf_pkg::BYTE_W-1:0]    i_data_byte,
    input  wire logic                          i_byte_valid,
    input  wire logic                          i_is_last,
    output logic                               o_strobe,
    output logic [mmf_pkg::STATUS_W-1:0]       o_status,
    output logic [mmf_pkg::BYTE_W-1:0]         o_out_byte,
    output logic [mmf_pkg::SENDER_W-1:0]       o_out_sender,
    output logic [mmf_pkg::LENGTH_W-1:0]       o_out_length,
    output logic                               o_out_valid,
    output logic                               o_last
);
    import mmf_pkg::*;

    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int AW    = SW + IW;
    localparam int DEPTH = 1 << AW;

    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [LW-1:0] LEN_MAX   = LW'(MAX_LEN);

    // Ring and send state.
    logic [SW-1:0] r_head, n_head;
    logic [SW-1:0] r_tail, n_tail;
    logic [LW-1:0] r_wc, n_wc;
    logic          r_in_msg, n_in_msg;
    logic          r_ovf, n_ovf;

    // Slot storage.
    logic [BYTE_W-1:0]   r_slot_bytes [DEPTH];
    logic [LW-1:0]       r_slot_len   [SLOTS];
    logic [ID_WIDTH-1:0] r_slot_snd   [SLOTS];
    logic [BYTE_W-1:0]   r_rd_data;
    logic [LW-1:0]       r_len_rd;
    logic [ID_WIDTH-1:0] r_snd_rd;

    // Receive sequencing.
    logic [SW-1:0]       r_rx_slot;
    logic [LW-1:0]       r_rx_len;
    logic [ID_WIDTH-1:0] r_rx_snd;
    logic [LW-1:0]       r_rd_idx;
    logic [AW-1:0]       rd_addr;

    // Result registers.
    logic                r_strobe, n_strobe;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic [SENDER_W-1:0] r_sender, n_sender;
    logic [LENGTH_W-1:0] r_len, n_len;
    logic                r_valid, n_valid;
    logic                r_last, n_last;

    // Send element helpers.
    logic [SW-1:0]       next_head;
    logic [SW-1:0]       next_tail;
    logic                full;
    logic [LW-1:0]       wc_base;
    logic                ovf_base;
    logic                store;
    logic                drop;
    logic [LW-1:0]       wc_new;
    logic                ovf_new;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic                len_we;
    logic                snd_we;
    logic [ID_WIDTH-1:0] sender_in;

    assign next_head = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign next_tail = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
    assign full      = (next_head == r_tail);
    assign sender_in = ID_WIDTH'(i_sender_id);

    // A first element starts a fresh byte count for the message.
    assign wc_base   = r_in_msg ? r_wc : '0;
    assign ovf_base  = r_in_msg && r_ovf;
    assign store     = i_byte_valid && (wc_base < LEN_MAX);
    assign drop      = i_byte_valid && !store;
    assign wc_new    = wc_base + LW'(store);
    assign ovf_new   = ovf_base || drop;
    assign mem_waddr = {r_head, wc_base[IW-1:0]};
    assign rd_addr   = {r_rx_slot, r_rd_idx[IW-1:0]};

    // Status towards the controller.
    assign o_sts.empty    = (r_head == r_tail);
    assign o_sts.zero_len = (r_len_rd == '0);
    assign o_sts.rx_last  = (r_rd_idx == r_rx_len);

    // Next values of the ring state and of the result.
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_wc     = r_wc;
        n_in_msg = r_in_msg;
        n_ovf    = r_ovf;
        n_strobe = 1'b0;
        n_status = ST_STORED;
        n_byte   = '0;
        n_sender = '0;
        n_len    = '0;
        n_valid  = 1'b0;
        n_last   = 1'b0;
        mem_we   = 1'b0;
        len_we   = 1'b0;
        snd_we   = 1'b0;
        if (i_cmd.send) begin
            n_strobe = 1'b1;
            n_last   = 1'b1;
            if (!r_in_msg && full) begin
                n_status = ST_FULL;
            end else begin
                snd_we = !r_in_msg;
                mem_we = store;
                n_wc   = wc_new;
                n_ovf  = ovf_new;
                n_len  = LENGTH_W'(wc_new);
                if (i_is_last) begin
                    len_we   = 1'b1;
                    n_head   = next_head;
                    n_in_msg = 1'b0;
                    n_status = ovf_new ? ST_TRUNCATED : ST_COMMITTED;
                end else begin
                    n_in_msg = 1'b1;
                    n_status = drop ? ST_TRUNCATED : ST_STORED;
                end
            end
        end else if (i_cmd.recv) begin
            if (o_sts.empty) begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                n_status = ST_EMPTY;
            end else begin
                n_tail = next_tail;
            end
        end else if (i_cmd.meta) begin
            // A message without bytes answers with a single result.
            if (o_sts.zero_len) begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                n_status = ST_DELIVERED;
                n_sender = SENDER_W'(r_snd_rd);
            end
        end else if (i_cmd.stream) begin
            n_strobe = 1'b1;
            n_status = ST_DELIVERED;
            n_byte   = r_rd_data;
            n_sender = SENDER_W'(r_rx_snd);
            n_len    = LENGTH_W'(r_rx_len);
            n_valid  = 1'b1;
            n_last   = o_sts.rx_last;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_wc     <= '0;
            r_in_msg <= 1'b0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_wc     <= n_wc;
            r_in_msg <= n_in_msg;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_byte   <= n_byte;
        r_sender <= n_sender;
        r_len    <= n_len;
        r_valid  <= n_valid;
        r_last   <= n_last;
    end

    // Byte memory: one write port at the head, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_bytes[mem_waddr] <= i_data_byte;
        end
        r_rd_data <= r_slot_bytes[rd_addr];
    end

    // Per-slot length and sender, read registered at the tail.
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_slot_len[r_head] <= wc_new;
        end
        if (snd_we) begin
            r_slot_snd[r_head] <= sender_in;
        end
        r_len_rd <= r_slot_len[r_tail];
        r_snd_rd <= r_slot_snd[r_tail];
    end

    // Receive sequencing: the byte read is registered ahead of delivery.
    always_ff @(posedge i_clk) begin
        if (i_cmd.recv) begin
            r_rx_slot <= r_tail;
            r_rd_idx  <= '0;
        end else if (i_cmd.meta || i_cmd.stream) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        if (i_cmd.meta) begin
            r_rx_len <= r_len_rd;
            r_rx_snd <= r_snd_rd;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_out_byte   = r_byte;
    assign o_out_sender = r_sender;
    assign o_out_length = r_len;
    assign o_out_valid  = r_valid;
    assign o_last       = r_last;

    // The stored count of a message never passes the length limit.
    a_wc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wc <= LEN_MAX)
        else $error("write count beyond the message length limit");

    // A refused send leaves the ring full and no message open.
    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status == ST_FULL) |-> (full && !r_in_msg))
        else $error("send refused although the ring had room");

    // An empty answer is given only when head and tail meet.
    a_empty_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status == ST_EMPTY) |-> (r_head == r_tail))
        else $error("empty answer on a ring holding messages");

    // Content bytes come only from the delivery stream.
    a_byte_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_valid) |-> (r_status == ST_DELIVERED && $past(i_cmd.stream)))
        else $error("content byte outside a delivery");

endmodule

`default_nettype wire
